FILE: rtl/core/utf8_to_ucs2_decoder_with_raw_fallback_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_TO_UCS2_DECODER_WITH_RAW_FALLBACK_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_WITH_RAW_FALLBACK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, muted while reset is asserted.
`define U2U_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also checked during reset.
`define U2U_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define U2U_ASSERT(lbl, clk, rst_n, prop, msg)

`define U2U_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/core/u2u_pkg.sv
// Types, constants and lead byte decode for the UTF-8 to UCS-2 decoder.
`default_nettype none

package u2u_pkg;

    // Default string buffer depth in bytes.
    localparam int MAX_BYTES_DEF = 64;

    // Lead byte masks and tags for sequences of six down to two bytes.
    localparam logic [7:0] LEAD6_MASK = 8'hFE;
    localparam logic [7:0] LEAD6_TAG  = 8'hFC;
    localparam logic [7:0] LEAD5_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_TAG  = 8'hF8;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] HIGH_BIT   = 8'h80;

    // Payload masks of the lead bytes.
    localparam logic [7:0] PAY6_MASK = 8'h01;
    localparam logic [7:0] PAY5_MASK = 8'h03;
    localparam logic [7:0] PAY4_MASK = 8'h07;
    localparam logic [7:0] PAY3_MASK = 8'h0F;
    localparam logic [7:0] PAY2_MASK = 8'h1F;

    // Continuation bytes carry 10 in their top two bits and six payload bits.
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // Input word: one byte of the string and its end mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // Output word: one code unit or raw byte and its flags.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        raw_fallback;
        logic        overflowed;
        logic        last_unit;
    } t_out_word;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_ACCEPT,
        S_READ,
        S_SHOW
    } t_state;

    // Classes of a byte seen in lead position.
    typedef enum logic [1:0] {
        LK_ASCII,
        LK_SEQ,
        LK_BAD
    } t_lead_kind;

    typedef struct packed {
        t_lead_kind kind;
        logic [2:0] pend;
        logic [7:0] payload;
    } t_lead;

    // Classify a lead byte: continuations expected and the payload it keeps.
    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead r;
        r.kind    = LK_ASCII;
        r.pend    = 3'd0;
        r.payload = b;
        if ((b & LEAD6_MASK) == LEAD6_TAG) begin
            r.kind    = LK_SEQ;
            r.pend    = 3'd5;
            r.payload = b & PAY6_MASK;
        end else if ((b & LEAD5_MASK) == LEAD5_TAG) begin
            r.kind    = LK_SEQ;
            r.pend    = 3'd4;
            r.payload = b & PAY5_MASK;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            r.kind    = LK_SEQ;
            r.pend    = 3'd3;
            r.payload = b & PAY4_MASK;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            r.kind    = LK_SEQ;
            r.pend    = 3'd2;
            r.payload = b & PAY3_MASK;
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            r.kind    = LK_SEQ;
            r.pend    = 3'd1;
            r.payload = b & PAY2_MASK;
        end else if ((b & HIGH_BIT) == HIGH_BIT) begin
            r.kind    = LK_BAD;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/u2u_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module u2u_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, read every cycle.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_to_ucs2_decoder_with_raw_fallback.sv
// Top level of the UTF-8 to UCS-2 decoder with raw byte fallback.
//
//   channel  | valid        | ready        | word
//   ---------+--------------+--------------+---------------------------
//   input    | i_in_valid   | o_in_ready   | i_in_word  (byte, last mark)
//   output   | o_out_valid  | i_out_ready  | o_out_word (unit and flags)
//
// Bytes are taken one per cycle while a string is being gathered; the decode
// step of one byte runs through the shared lead/continuation unit in that cycle.
// After the last byte the input closes and the block emits n words; for each word
// S_READ reads the byte or unit RAM at its single read port and S_SHOW then shows it.
// Output stalls simply hold the shown word; the input reopens after the last word.
// Reset is synchronous and clears the sequencer and counters; the RAMs need none.
`default_nettype none

`include "utf8_to_ucs2_decoder_with_raw_fallback_macros.svh"

module utf8_to_ucs2_decoder_with_raw_fallback #(
    parameter int MAX_BYTES = u2u_pkg::MAX_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire u2u_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output u2u_pkg::t_out_word      o_out_word
);

    import u2u_pkg::*;

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_byte_cnt, n_byte_cnt;
    logic [CW-1:0] r_unit_cnt, n_unit_cnt;
    logic [2:0]    r_pend, n_pend;
    logic [15:0]   r_acc, n_acc;
    logic          r_invalid, n_invalid;
    logic          r_ovf, n_ovf;
    logic          r_raw, n_raw;
    logic          r_ovf_out, n_ovf_out;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_last_idx, n_last_idx;

    logic          in_acc;
    logic          out_acc;
    logic          have_room;
    logic          fin_invalid;
    logic [CW-1:0] fin_count;
    logic          raw_we;
    logic          unit_we;
    logic [15:0]   unit_wdata;
    logic [7:0]    raw_rdata;
    logic [15:0]   unit_rdata;
    logic          at_last;
    t_lead         lead;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_acc   = o_out_valid && i_out_ready;
    assign have_room = (r_byte_cnt < CW'(MAX_BYTES));
    assign at_last   = (r_idx == r_last_idx);
    assign lead      = lead_decode(i_in_word.data_byte);

    // Byte step: store raw, run the decode unit, close the string on the last byte.
    always_comb begin
        n_byte_cnt  = r_byte_cnt;
        n_unit_cnt  = r_unit_cnt;
        n_pend      = r_pend;
        n_acc       = r_acc;
        n_invalid   = r_invalid;
        n_ovf       = r_ovf;
        n_raw       = r_raw;
        n_ovf_out   = r_ovf_out;
        n_last_idx  = r_last_idx;
        raw_we      = 1'b0;
        unit_we     = 1'b0;
        unit_wdata  = r_acc;
        fin_invalid = 1'b0;
        fin_count   = '0;
        if (in_acc) begin
            if (have_room) begin
                raw_we     = 1'b1;
                n_byte_cnt = r_byte_cnt + CW'(1);
                if (!r_invalid) begin
                    if (r_pend != 3'd0) begin
                        // Continuation expected: shift in six bits.
                        if (i_in_word.data_byte[7:6] != CONT_TAG) begin
                            n_invalid = 1'b1;
                        end else begin
                            n_acc  = {r_acc[9:0], i_in_word.data_byte[5:0]};
                            n_pend = r_pend - 3'd1;
                            if (r_pend == 3'd1) begin
                                unit_we    = 1'b1;
                                unit_wdata = n_acc;
                            end
                        end
                    end else begin
                        // Lead position.
                        case (lead.kind)
                            LK_ASCII: begin
                                unit_we    = 1'b1;
                                unit_wdata = {8'h00, i_in_word.data_byte};
                            end
                            LK_SEQ: begin
                                n_acc  = {8'h00, lead.payload};
                                n_pend = lead.pend;
                            end
                            default: begin
                                n_invalid = 1'b1;
                            end
                        endcase
                    end
                end
            end else begin
                n_ovf = 1'b1;
            end

            // Unit write, bounded by the buffer depth.
            if (unit_we) begin
                if (r_unit_cnt < CW'(MAX_BYTES)) begin
                    n_unit_cnt = r_unit_cnt + CW'(1);
                end else begin
                    unit_we = 1'b0;
                end
            end

            // End of string: latch the emit setup and clear the gathering state.
            if (i_in_word.last_byte) begin
                fin_invalid = n_invalid || (n_pend != 3'd0);
                fin_count   = fin_invalid ? n_byte_cnt : n_unit_cnt;
                n_raw       = fin_invalid;
                n_ovf_out   = n_ovf;
                n_last_idx  = AW'(fin_count - CW'(1));
                n_byte_cnt  = '0;
                n_unit_cnt  = '0;
                n_pend      = 3'd0;
                n_acc       = '0;
                n_invalid   = 1'b0;
                n_ovf       = 1'b0;
            end
        end
    end

    // Emit index.
    always_comb begin
        n_idx = r_idx;
        if (in_acc && i_in_word.last_byte) begin
            n_idx = '0;
        end else if (out_acc && !at_last) begin
            n_idx = r_idx + AW'(1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ACCEPT: begin
                if (in_acc && i_in_word.last_byte) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (i_out_ready) begin
                    n_state = at_last ? S_ACCEPT : S_READ;
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_ACCEPT: begin
                o_in_ready = 1'b1;
            end
            S_SHOW: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    // Output word from the RAM read registers and the latched flags.
    always_comb begin
        o_out_word.code_unit    = r_raw ? {8'h00, raw_rdata} : unit_rdata;
        o_out_word.raw_fallback = r_raw;
        o_out_word.overflowed   = r_ovf_out;
        o_out_word.last_unit    = at_last;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ACCEPT;
            r_byte_cnt <= '0;
            r_unit_cnt <= '0;
            r_pend     <= 3'd0;
            r_acc      <= '0;
            r_invalid  <= 1'b0;
            r_ovf      <= 1'b0;
            r_raw      <= 1'b0;
            r_ovf_out  <= 1'b0;
            r_idx      <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_byte_cnt <= n_byte_cnt;
            r_unit_cnt <= n_unit_cnt;
            r_pend     <= n_pend;
            r_acc      <= n_acc;
            r_invalid  <= n_invalid;
            r_ovf      <= n_ovf;
            r_raw      <= n_raw;
            r_ovf_out  <= n_ovf_out;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
        end
    end

    // Raw byte store.
    u2u_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES),
        .ADDR_W(AW)
    ) u_raw_ram (
        .i_clk    (i_clk),
        .i_wr_en  (raw_we),
        .i_wr_addr(r_byte_cnt[AW-1:0]),
        .i_wr_data(i_in_word.data_byte),
        .i_rd_addr(r_idx),
        .o_rd_data(raw_rdata)
    );

    // Decoded unit store.
    u2u_ram #(
        .WIDTH (16),
        .DEPTH (MAX_BYTES),
        .ADDR_W(AW)
    ) u_unit_ram (
        .i_clk    (i_clk),
        .i_wr_en  (unit_we),
        .i_wr_addr(r_unit_cnt[AW-1:0]),
        .i_wr_data(unit_wdata),
        .i_rd_addr(r_idx),
        .o_rd_data(unit_rdata)
    );

    // The input and output sides are never open at the same time.
    `U2U_ASSERT_ALWAYS(a_one_side, i_clk, !(o_in_ready && o_out_valid), "both sides open")

    // No more units are decoded than bytes stored.
    `U2U_ASSERT(a_units_le_bytes, i_clk, i_rst_n, r_unit_cnt <= r_byte_cnt, "unit count ahead of byte count")

    // After the final word of a string, the block is ready for a new string.
    `U2U_ASSERT(a_reopen, i_clk, i_rst_n, (out_acc && o_out_word.last_unit) |=> (o_in_ready && r_byte_cnt == '0), "input not reopened after last word")

endmodule

`default_nettype wire
